### design/pncs_pkg.sv
// shared types and constants for the palette nearest color search
package pncs_pkg;

  // default number of palette entries
  localparam int DEFAULT_ENTRIES = 256;

  // channel and derived widths
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int INDEX_W = 8;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear_we;    // write black at the scan address
    logic wr_en;       // store the request color at its entry index
    logic load_query;  // capture the query color
    logic rd_en;       // read the entry at the scan address
    logic first;       // read is the first entry of a scan
    logic last;        // read is the last entry of a scan
  } cmd_t;

endpackage

### design/palette_nearest_color_search.sv
// top level of the palette nearest color search
// A write request (opcode 0) stores red/green/blue at entry_index and gives
// no result; an index at or beyond PALETTE_ENTRIES is ignored. A query
// request (opcode 1) scans the whole palette, one entry per cycle through a
// single squared-distance unit fed by the palette memory's one read port,
// and pulses done for one cycle with best_index (lowest index of least squared
// RGB distance, masked to 8 bits) and exact_match. The receiver cannot stall;
// the result stays on the ports after done until the next query's scan
// replaces it. A query keeps busy high until its done pulse has been given;
// a write leaves busy low. After reset busy stays high while a clearing pass
// writes every entry to black.
module palette_nearest_color_search #(
  parameter int PALETTE_ENTRIES = pncs_pkg::DEFAULT_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [pncs_pkg::INDEX_W-1:0]    entry_index,
  input  logic [pncs_pkg::CHAN_W-1:0]     red,
  input  logic [pncs_pkg::CHAN_W-1:0]     green,
  input  logic [pncs_pkg::CHAN_W-1:0]     blue,
  output logic                            done,
  output logic [pncs_pkg::INDEX_W-1:0]    best_index,
  output logic                            exact_match
);

  pncs_pkg::cmd_t                    cmd;
  logic [$clog2(PALETTE_ENTRIES)-1:0] addr;
  logic                              scan_done;

  // controller
  pncs_ctrl #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .scan_done (scan_done),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr)
  );

  // datapath
  pncs_datapath #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .addr        (addr),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .scan_done   (scan_done),
    .best_index  (best_index),
    .exact_match (exact_match)
  );

  assign done = scan_done;

endmodule

### design/pncs_ram.sv
// generic single write port ram with registered read
module pncs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pncs_ctrl.sv
// controller: clearing pass, request decode and scan sequencing
module pncs_ctrl #(
  parameter int ENTRIES = pncs_pkg::DEFAULT_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       opcode,
  input  logic                       scan_done,
  output logic                       busy,
  output pncs_pkg::cmd_t             cmd,
  output logic [$clog2(ENTRIES)-1:0] addr
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [AW-1:0] count;
  logic [AW-1:0] count_next;
  logic          accept;
  logic          at_last;

  assign accept  = start && (state == ST_IDLE);
  assign at_last = (count == LAST_ADDR);
  assign busy    = (state != ST_IDLE);
  assign addr    = count;

  // next state, counter and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (at_last) begin
          state_next = ST_IDLE;
          count_next = '0;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode == pncs_pkg::OP_QUERY) begin
            cmd.load_query = 1'b1;
            state_next     = ST_SCAN;
            count_next     = '0;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.first = (count == '0);
        cmd.last  = at_last;
        if (at_last) begin
          state_next = ST_WAIT;
          count_next = '0;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_WAIT: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

### design/pncs_datapath.sv
// datapath: palette store, distance pipeline and running minimum
module pncs_datapath #(
  parameter int ENTRIES = pncs_pkg::DEFAULT_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pncs_pkg::cmd_t                      cmd,
  input  logic [$clog2(ENTRIES)-1:0]          addr,
  input  logic [pncs_pkg::INDEX_W-1:0]        entry_index,
  input  logic [pncs_pkg::CHAN_W-1:0]         red,
  input  logic [pncs_pkg::CHAN_W-1:0]         green,
  input  logic [pncs_pkg::CHAN_W-1:0]         blue,
  output logic                                scan_done,
  output logic [pncs_pkg::INDEX_W-1:0]        best_index,
  output logic                                exact_match
);

  localparam int AW     = $clog2(ENTRIES);
  localparam int CW     = pncs_pkg::CHAN_W;
  localparam int SQ_W   = pncs_pkg::SQ_W;
  localparam int DIST_W = pncs_pkg::DIST_W;
  localparam int IW     = pncs_pkg::INDEX_W;
  localparam int EXT_W  = AW + IW;

  // write port selection: clearing pass or stored entry
  logic [EXT_W-1:0]              idx_ext;
  logic                          idx_in_range;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [pncs_pkg::COLOR_W-1:0]  ram_wdata;
  logic [pncs_pkg::COLOR_W-1:0]  ram_rdata;

  assign idx_ext      = EXT_W'(entry_index);
  assign idx_in_range = (32'(entry_index) < 32'(ENTRIES));
  assign ram_we       = cmd.clear_we || (cmd.wr_en && idx_in_range);
  assign ram_waddr    = cmd.clear_we ? addr : idx_ext[AW-1:0];
  assign ram_wdata    = cmd.clear_we ? '0 : {red, green, blue};

  pncs_ram #(
    .WIDTH (pncs_pkg::COLOR_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // query color
  logic [CW-1:0] q_red;
  logic [CW-1:0] q_green;
  logic [CW-1:0] q_blue;

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
    end
  end

  // stage 1: entry read from the store
  logic          v1;
  logic          f1;
  logic          l1;
  logic [AW-1:0] idx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
    end
    f1   <= cmd.first;
    l1   <= cmd.last;
    idx1 <= addr;
  end

  // absolute channel differences
  logic [CW-1:0] e_red;
  logic [CW-1:0] e_green;
  logic [CW-1:0] e_blue;
  logic [CW-1:0] d_red;
  logic [CW-1:0] d_green;
  logic [CW-1:0] d_blue;

  assign e_red   = ram_rdata[3*CW-1:2*CW];
  assign e_green = ram_rdata[2*CW-1:CW];
  assign e_blue  = ram_rdata[CW-1:0];
  assign d_red   = (e_red   >= q_red)   ? (e_red   - q_red)   : (q_red   - e_red);
  assign d_green = (e_green >= q_green) ? (e_green - q_green) : (q_green - e_green);
  assign d_blue  = (e_blue  >= q_blue)  ? (e_blue  - q_blue)  : (q_blue  - e_blue);

  // stage 2: squared differences
  logic            v2;
  logic            f2;
  logic            l2;
  logic [AW-1:0]   idx2;
  logic [SQ_W-1:0] sq_red;
  logic [SQ_W-1:0] sq_green;
  logic [SQ_W-1:0] sq_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    f2       <= f1;
    l2       <= l1;
    idx2     <= idx1;
    sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
  end

  // stage 3: distance sum and running minimum, lowest index kept on ties
  logic [DIST_W-1:0] distance;
  logic [DIST_W-1:0] least;
  logic [DIST_W-1:0] least_next;
  logic [AW-1:0]     best;
  logic [AW-1:0]     best_next;
  logic              take;

  assign distance = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  assign take     = v2 && (f2 || (distance < least));

  always_comb begin
    least_next = least;
    best_next  = best;
    if (take) begin
      least_next = distance;
      best_next  = idx2;
    end
  end

  always_ff @(posedge clk) begin
    least <= least_next;
    best  <= best_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b0;
    end else begin
      scan_done <= v2 && l2;
    end
  end

  // result fields, index masked to its 8 bits
  logic [EXT_W-1:0] best_ext;

  assign best_ext    = EXT_W'(best);
  assign best_index  = best_ext[IW-1:0];
  assign exact_match = (least == '0);

endmodule
